// ===== src/sfel_pkg.sv =====
// shared types, codes and helpers for the stack frame enter/leave block
`default_nettype none
package sfel_pkg;

	localparam int unsigned FifoDepth = 4;

	localparam logic [1:0] ACT_ENTER = 2'd0;
	localparam logic [1:0] ACT_LEAVE = 2'd1;
	localparam logic [1:0] ACT_RDATA = 2'd2;
	localparam logic [1:0] ACT_LOAD  = 2'd3;

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;

	localparam logic [15:0] WORD_BYTES = 16'd2;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ENTER,
		PH_LEAVE
	} phase_t;

	typedef struct packed {
		logic [15:0] sp;
		logic [15:0] bp;
		logic [15:0] sfp;
		logic [4:0]  levels;
		logic [15:0] locals;
		phase_t      phase;
	} frame_state_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] frame_bytes;
		logic [7:0]  nest_level;
		logic [15:0] read_data;
		logic [15:0] load_sp;
		logic [15:0] load_bp;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [19:0] addr;
		logic [15:0] wdata;
		logic        last;
		logic [15:0] sp;
		logic [15:0] bp;
	} result_t;

	// segment*16 + offset, wrapped to 20 bits
	function automatic logic [19:0] phys(input logic [15:0] seg, input logic [15:0] off);
		return {seg, 4'b0000} + {4'b0000, off};
	endfunction

	function automatic result_t mk_res(input logic [1:0] kind, input logic [19:0] addr,
			input logic [15:0] wdata, input logic last, input logic [15:0] sp,
			input logic [15:0] bp);
		result_t r;
		r.kind  = kind;
		r.addr  = addr;
		r.wdata = wdata;
		r.last  = last;
		r.sp    = sp;
		r.bp    = bp;
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== src/sfel_step.sv =====
// next-state and result logic for one enter/leave item
`default_nettype none
module sfel_step (
	input  wire sfel_pkg::frame_state_t st,
	input  wire sfel_pkg::item_t        item,
	input  wire logic [15:0]            seg,
	output sfel_pkg::frame_state_t      nxt,
	output logic [1:0]                  n_res,
	output sfel_pkg::result_t           res0,
	output sfel_pkg::result_t           res1
);

	logic [15:0] sp_dec;
	logic [15:0] sp_dec2;
	logic [15:0] bp_dec;
	logic [4:0]  level;
	logic [4:0]  lvl_dec;

	always_comb begin
		sp_dec  = st.sp - sfel_pkg::WORD_BYTES;
		sp_dec2 = sp_dec - sfel_pkg::WORD_BYTES;
		bp_dec  = st.bp - sfel_pkg::WORD_BYTES;
		level   = item.nest_level[4:0];
		lvl_dec = (st.levels != 5'd0) ? st.levels - 5'd1 : 5'd0;

		nxt   = st;
		n_res = 2'd0;
		res0  = '0;
		res1  = '0;

		case (item.action)
			sfel_pkg::ACT_ENTER: begin
				if (st.phase == sfel_pkg::PH_IDLE) begin
					n_res      = 2'd2;
					res0       = sfel_pkg::mk_res(sfel_pkg::KIND_WRITE,
						sfel_pkg::phys(seg, sp_dec), st.bp, 1'b0, sp_dec, st.bp);
					nxt.sfp    = sp_dec;
					nxt.locals = item.frame_bytes;
					if (level == 5'd0) begin
						nxt.bp = sp_dec;
						nxt.sp = sp_dec - item.frame_bytes;
						res1   = sfel_pkg::mk_res(sfel_pkg::KIND_DONE, 20'd0, 16'd0, 1'b1,
							sp_dec - item.frame_bytes, sp_dec);
					end else if (level == 5'd1) begin
						nxt.bp = sp_dec;
						nxt.sp = sp_dec2 - item.frame_bytes;
						res1   = sfel_pkg::mk_res(sfel_pkg::KIND_WRITE,
							sfel_pkg::phys(seg, sp_dec2), sp_dec, 1'b1,
							sp_dec2 - item.frame_bytes, sp_dec);
					end else begin
						// copy outer frame pointers, first read goes out now
						nxt.sp     = sp_dec;
						nxt.bp     = bp_dec;
						nxt.levels = level - 5'd1;
						nxt.phase  = sfel_pkg::PH_ENTER;
						res1       = sfel_pkg::mk_res(sfel_pkg::KIND_READ,
							sfel_pkg::phys(seg, bp_dec), 16'd0, 1'b1, sp_dec, bp_dec);
					end
				end
			end
			sfel_pkg::ACT_LEAVE: begin
				if (st.phase == sfel_pkg::PH_IDLE) begin
					n_res     = 2'd1;
					nxt.sp    = st.bp;
					nxt.phase = sfel_pkg::PH_LEAVE;
					res0      = sfel_pkg::mk_res(sfel_pkg::KIND_READ,
						sfel_pkg::phys(seg, st.bp), 16'd0, 1'b1, st.bp, st.bp);
				end
			end
			sfel_pkg::ACT_RDATA: begin
				if (st.phase == sfel_pkg::PH_ENTER) begin
					n_res      = 2'd2;
					nxt.levels = lvl_dec;
					res0       = sfel_pkg::mk_res(sfel_pkg::KIND_WRITE,
						sfel_pkg::phys(seg, sp_dec), item.read_data, 1'b0, sp_dec, st.bp);
					if (lvl_dec != 5'd0) begin
						nxt.sp = sp_dec;
						nxt.bp = bp_dec;
						res1   = sfel_pkg::mk_res(sfel_pkg::KIND_READ,
							sfel_pkg::phys(seg, bp_dec), 16'd0, 1'b1, sp_dec, bp_dec);
					end else begin
						// last copy done: push frame pointer and finish
						nxt.sp    = sp_dec2 - st.locals;
						nxt.bp    = st.sfp;
						nxt.phase = sfel_pkg::PH_IDLE;
						res1      = sfel_pkg::mk_res(sfel_pkg::KIND_WRITE,
							sfel_pkg::phys(seg, sp_dec2), st.sfp, 1'b1,
							sp_dec2 - st.locals, st.sfp);
					end
				end else if (st.phase == sfel_pkg::PH_LEAVE) begin
					n_res     = 2'd1;
					nxt.sp    = st.sp + sfel_pkg::WORD_BYTES;
					nxt.bp    = item.read_data;
					nxt.phase = sfel_pkg::PH_IDLE;
					res0      = sfel_pkg::mk_res(sfel_pkg::KIND_DONE, 20'd0, 16'd0, 1'b1,
						st.sp + sfel_pkg::WORD_BYTES, item.read_data);
				end
			end
			sfel_pkg::ACT_LOAD: begin
				if (st.phase == sfel_pkg::PH_IDLE) begin
					n_res  = 2'd1;
					nxt.sp = item.load_sp;
					nxt.bp = item.load_bp;
					res0   = sfel_pkg::mk_res(sfel_pkg::KIND_DONE, 20'd0, 16'd0, 1'b1,
						item.load_sp, item.load_bp);
				end
			end
			default: begin
				n_res = 2'd0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== src/stack_frame_enter_leave.sv =====
// top level of the x86 enter/leave stack frame block
`default_nettype none
// Runs x86 ENTER and LEAVE against an external stack. The block holds the
// stack pointer and frame base and emits one result per stack access:
// writes (pushes), read requests, and completions that carry no access.
// Addresses are stack_segment*16 + offset, wrapped to 20 bits. For ENTER
// with nesting level above one, every copy read must be answered by a
// read-data item (action 2) before the next copy goes out; LEAVE likewise
// waits for the popped word. Items that arrive in the wrong phase are
// consumed silently. An accepted item is held in the input register and
// worked there, and its zero, one or two results enter a four-entry
// result queue; the first can be taken on the following cycle. The result
// port moves one transfer per cycle while out_ready is high, so items that
// cause two accesses are held back by the port and single-result items
// run at one per cycle. The input side keeps accepting while results wait,
// as long as the queue has room for two more. Configuration writes to
// cfg_data set the stack segment and are always accepted.
module stack_frame_enter_leave (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// item input channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [15:0] frame_bytes,
	input  wire logic [7:0]  nest_level,
	input  wire logic [15:0] read_data,
	input  wire logic [15:0] load_sp,
	input  wire logic [15:0] load_bp,
	// result channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       access_kind,
	output logic [19:0]      address,
	output logic [15:0]      write_data,
	output logic             last,
	output logic [15:0]      stack_pointer_out,
	output logic [15:0]      frame_base_out,
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);

	localparam int unsigned PtrW = $clog2(sfel_pkg::FifoDepth);
	localparam int unsigned CntW = $clog2(sfel_pkg::FifoDepth + 1);
	localparam logic [CntW-1:0] Room = CntW'(sfel_pkg::FifoDepth - 2);

	// stack segment register
	logic [15:0] seg_q;

	// input register stage
	logic            valid_s1;
	sfel_pkg::item_t item_s1;

	// architectural state
	sfel_pkg::frame_state_t st_q;
	sfel_pkg::frame_state_t st_nxt;

	// step results
	logic [1:0]        n_res;
	sfel_pkg::result_t res0;
	sfel_pkg::result_t res1;

	// result queue
	sfel_pkg::result_t res_q [sfel_pkg::FifoDepth];
	logic [PtrW-1:0]   head_q;
	logic [PtrW-1:0]   tail_q;
	logic [CntW-1:0]   count_q;

	logic            pop;
	logic [CntW-1:0] count_after_pop;
	logic            fire_s1;
	logic [CntW-1:0] n_push;

	sfel_step u_step (
		.st    (st_q),
		.item  (item_s1),
		.seg   (seg_q),
		.nxt   (st_nxt),
		.n_res (n_res),
		.res0  (res0),
		.res1  (res1)
	);

	// queue pop this cycle frees a slot for the step that writes now
	assign pop             = out_valid && out_ready;
	assign count_after_pop = count_q - {{(CntW-1){1'b0}}, pop};
	// worst case an item leaves two results, so hold it until room for two
	assign fire_s1         = valid_s1 && (count_after_pop <= Room);
	assign in_ready        = !valid_s1 || fire_s1;
	assign n_push          = fire_s1 ? CntW'(n_res) : '0;

	assign cfg_ready = 1'b1;

	// head of the queue drives the result port
	assign out_valid         = (count_q != '0);
	assign access_kind       = res_q[head_q].kind;
	assign address           = res_q[head_q].addr;
	assign write_data        = res_q[head_q].wdata;
	assign last              = res_q[head_q].last;
	assign stack_pointer_out = res_q[head_q].sp;
	assign frame_base_out    = res_q[head_q].bp;

	// control: segment, input valid, state, queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q    <= '0;
			valid_s1 <= 1'b0;
			st_q     <= '{sp: '0, bp: '0, sfp: '0, levels: '0, locals: '0,
				phase: sfel_pkg::PH_IDLE};
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				seg_q <= cfg_data;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (fire_s1) begin
				st_q   <= st_nxt;
				tail_q <= tail_q + PtrW'(n_res);
			end
			if (pop) begin
				head_q <= head_q + PtrW'(1);
			end
			count_q <= count_after_pop + n_push;
		end
	end

	// payload: input register and queue entries
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= '{action: action, frame_bytes: frame_bytes, nest_level: nest_level,
				read_data: read_data, load_sp: load_sp, load_bp: load_bp};
		end
		if (fire_s1 && (n_res != 2'd0)) begin
			res_q[tail_q] <= res0;
		end
		if (fire_s1 && (n_res == 2'd2)) begin
			res_q[tail_q + PtrW'(1)] <= res1;
		end
	end

endmodule
`default_nettype wire

// ===== tb/sfel_access_checker.sv =====
// checker for the stack frame enter/leave block: predicts stack accesses and compares them
module sfel_access_checker
	import sfel_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  action,
	input  logic [15:0] frame_bytes,
	input  logic [7:0]  nest_level,
	input  logic [15:0] read_data,
	input  logic [15:0] load_sp,
	input  logic [15:0] load_bp,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  access_kind,
	input  logic [19:0] address,
	input  logic [15:0] write_data,
	input  logic        last,
	input  logic [15:0] stack_pointer_out,
	input  logic [15:0] frame_base_out,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        wrap_up,
	output int          mismatches,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// shadow copy of the block's registers
	logic [15:0] m_seg    = '0;
	logic [15:0] m_sp     = '0;
	logic [15:0] m_bp     = '0;
	logic [15:0] m_sfp    = '0;
	logic [7:0]  m_levels = '0;
	logic [15:0] m_locals = '0;
	phase_t      m_phase  = PH_IDLE;

	result_t expected_accesses[$];
	int      fail_count    = 0;
	int      backlog       = 0;
	bit      leftover_seen = 1'b0;

	assign mismatches = fail_count;
	assign pending    = backlog;

	function automatic logic [19:0] stack_addr(input logic [15:0] off);
		return {m_seg, 4'b0000} + 20'(off);
	endfunction

	// queue one access, tagged with the registers as they stand now
	task automatic queue_access(input logic [1:0] kind, input logic [19:0] addr,
			input logic [15:0] wdata, input logic fin);
		result_t r;
		r.kind  = kind;
		r.addr  = addr;
		r.wdata = wdata;
		r.last  = fin;
		r.sp    = m_sp;
		r.bp    = m_bp;
		expected_accesses.push_back(r);
	endtask

	// push of the frame pointer, carrying the finished frame registers
	task automatic push_frame_pointer();
		logic [19:0] a;
		m_sp    = m_sp - WORD_BYTES;
		a       = stack_addr(m_sp);
		m_bp    = m_sfp;
		m_sp    = m_sp - m_locals;
		m_phase = PH_IDLE;
		queue_access(KIND_WRITE, a, m_sfp, 1'b1);
	endtask

	task automatic copy_read();
		m_bp = m_bp - WORD_BYTES;
		queue_access(KIND_READ, stack_addr(m_bp), 16'h0000, 1'b1);
	endtask

	task automatic frame_step(input item_t it);
		logic [4:0] lvl;
		lvl = it.nest_level[4:0];
		case (it.action)
			ACT_ENTER: if (m_phase == PH_IDLE) begin
				m_sp = m_sp - WORD_BYTES;
				queue_access(KIND_WRITE, stack_addr(m_sp), m_bp, 1'b0);
				m_sfp    = m_sp;
				m_locals = it.frame_bytes;
				if (lvl == 5'd0) begin
					m_bp = m_sfp;
					m_sp = m_sp - m_locals;
					queue_access(KIND_DONE, 20'h00000, 16'h0000, 1'b1);
				end else if (lvl == 5'd1) begin
					push_frame_pointer();
				end else begin
					m_levels = 8'(lvl) - 8'd1;
					m_phase  = PH_ENTER;
					copy_read();
				end
			end
			ACT_LEAVE: if (m_phase == PH_IDLE) begin
				m_sp    = m_bp;
				m_phase = PH_LEAVE;
				queue_access(KIND_READ, stack_addr(m_sp), 16'h0000, 1'b1);
			end
			ACT_RDATA: if (m_phase == PH_ENTER) begin
				m_sp = m_sp - WORD_BYTES;
				queue_access(KIND_WRITE, stack_addr(m_sp), it.read_data, 1'b0);
				if (m_levels != 0)
					m_levels = m_levels - 8'd1;
				if (m_levels != 0)
					copy_read();
				else
					push_frame_pointer();
			end else if (m_phase == PH_LEAVE) begin
				m_bp    = it.read_data;
				m_sp    = m_sp + WORD_BYTES;
				m_phase = PH_IDLE;
				queue_access(KIND_DONE, 20'h00000, 16'h0000, 1'b1);
			end
			ACT_LOAD: if (m_phase == PH_IDLE) begin
				m_sp = it.load_sp;
				m_bp = it.load_bp;
				queue_access(KIND_DONE, 20'h00000, 16'h0000, 1'b1);
			end
		endcase
	endtask

	task automatic compare_field(input string name, input logic [19:0] want,
			input logic [19:0] got);
		if (want !== got) begin
			$error("mismatch on %s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		item_t   it;
		result_t want;
		if (!arst_n) begin
			m_seg    = '0;
			m_sp     = '0;
			m_bp     = '0;
			m_sfp    = '0;
			m_levels = '0;
			m_locals = '0;
			m_phase  = PH_IDLE;
			expected_accesses.delete();
			backlog <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				m_seg = cfg_data;
			if (in_valid && in_ready) begin
				it.action      = action;
				it.frame_bytes = frame_bytes;
				it.nest_level  = nest_level;
				it.read_data   = read_data;
				it.load_sp     = load_sp;
				it.load_bp     = load_bp;
				frame_step(it);
			end
			if (out_valid && out_ready) begin
				if (expected_accesses.size() == 0) begin
					$error("access with none expected: kind %0d addr %0h",
						access_kind, address);
					fail_count++;
				end else begin
					want = expected_accesses.pop_front();
					compare_field("access_kind", want.kind, access_kind);
					compare_field("address", want.addr, address);
					compare_field("write_data", want.wdata, write_data);
					compare_field("last", want.last, last);
					compare_field("stack_pointer_out", want.sp, stack_pointer_out);
					compare_field("frame_base_out", want.bp, frame_base_out);
				end
			end
			if (wrap_up && !leftover_seen && expected_accesses.size() != 0) begin
				$error("%0d expected accesses never arrived", expected_accesses.size());
				fail_count++;
				leftover_seen = 1'b1;
			end
			backlog <= expected_accesses.size();
		end
	end

endmodule

// ===== tb/tb_stack_frame_enter_leave.sv =====
// top of the stack frame enter/leave testbench: clock, reset, stimulus and verdict
module tb_stack_frame_enter_leave;
	timeunit 1ns;
	timeprecision 1ps;
	import sfel_pkg::*;

	localparam int CycleLimit   = 200000;
	localparam int PhaseItems   = 110;   // counted items per random phase
	localparam int SettleCycles = 8;     // input register plus result queue, with margin

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic [1:0]  action      = ACT_LOAD;
	logic [15:0] frame_bytes = '0;
	logic [7:0]  nest_level  = '0;
	logic [15:0] read_data   = '0;
	logic [15:0] load_sp     = '0;
	logic [15:0] load_bp     = '0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	logic [1:0]  access_kind;
	logic [19:0] address;
	logic [15:0] write_data;
	logic        last;
	logic [15:0] stack_pointer_out;
	logic [15:0] frame_base_out;
	logic        cfg_valid   = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data    = '0;
	logic        wrap_up     = 1'b0;

	int mismatches;
	int pending;

	// idle percentages for the sender and the receiver
	int tx_idle_pct = 24;
	int rx_idle_pct = 51;

	// where the stimulus thinks the block stands: which phase and how many
	// data returns it still owes; decides whether an item counts or is noise
	phase_t seq_phase = PH_IDLE;
	int     seq_owed  = 0;

	int n_counted = 0;
	int n_ignored = 0;
	int n_enter   = 0;
	int n_leave   = 0;
	int n_rdata   = 0;
	int n_load    = 0;
	int n_cfg     = 0;
	int unsigned cycle_count = 0;

	stack_frame_enter_leave i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.action           (action),
		.frame_bytes      (frame_bytes),
		.nest_level       (nest_level),
		.read_data        (read_data),
		.load_sp          (load_sp),
		.load_bp          (load_bp),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.access_kind      (access_kind),
		.address          (address),
		.write_data       (write_data),
		.last             (last),
		.stack_pointer_out(stack_pointer_out),
		.frame_base_out   (frame_base_out),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data)
	);

	sfel_access_checker i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.action           (action),
		.frame_bytes      (frame_bytes),
		.nest_level       (nest_level),
		.read_data        (read_data),
		.load_sp          (load_sp),
		.load_bp          (load_bp),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.access_kind      (access_kind),
		.address          (address),
		.write_data       (write_data),
		.last             (last),
		.stack_pointer_out(stack_pointer_out),
		.frame_base_out   (frame_base_out),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.wrap_up          (wrap_up),
		.mismatches       (mismatches),
		.pending          (pending)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver backpressure, redrawn every cycle
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("timeout after %0d cycles, %0d accesses still expected",
				cycle_count, pending);
			$display("status: fail");
			$finish;
		end
	end

	// present one item, with random sender gaps ahead of it, and hold it
	// until the transfer; valid stays high into the next item when no gap
	task automatic issue(input item_t it);
		bit counted;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		action      <= it.action;
		frame_bytes <= it.frame_bytes;
		nest_level  <= it.nest_level;
		read_data   <= it.read_data;
		load_sp     <= it.load_sp;
		load_bp     <= it.load_bp;
		do @(posedge clk); while (!in_ready);
		// follow the phase so that noise items are known as such
		counted = 1'b0;
		case (it.action)
			ACT_ENTER: if (seq_phase == PH_IDLE) begin
				counted = 1'b1;
				n_enter++;
				if (it.nest_level[4:0] >= 5'd2) begin
					seq_phase = PH_ENTER;
					seq_owed  = int'(it.nest_level[4:0]) - 1;
				end
			end
			ACT_LEAVE: if (seq_phase == PH_IDLE) begin
				counted = 1'b1;
				n_leave++;
				seq_phase = PH_LEAVE;
				seq_owed  = 1;
			end
			ACT_RDATA: if (seq_phase != PH_IDLE) begin
				counted = 1'b1;
				n_rdata++;
				seq_owed--;
				if (seq_owed == 0)
					seq_phase = PH_IDLE;
			end
			ACT_LOAD: if (seq_phase == PH_IDLE) begin
				counted = 1'b1;
				n_load++;
			end
		endcase
		if (counted)
			n_counted++;
		else
			n_ignored++;
	endtask

	// directed shorthand: a is frame_bytes, read_data or load_sp by action,
	// b is load_bp; fields the action does not use get random values
	task automatic put(input logic [1:0] act, input logic [15:0] a, input logic [15:0] b,
			input logic [7:0] lvl);
		item_t it;
		it.action      = act;
		it.frame_bytes = (act == ACT_ENTER) ? a : 16'($urandom);
		it.nest_level  = (act == ACT_ENTER) ? lvl : 8'($urandom);
		it.read_data   = (act == ACT_RDATA) ? a : 16'($urandom);
		it.load_sp     = (act == ACT_LOAD) ? a : 16'($urandom);
		it.load_bp     = (act == ACT_LOAD) ? b : 16'($urandom);
		issue(it);
	endtask

	// hold the sender off until every expected access has come back; the
	// first edge lets the checker take in an item accepted just now
	task automatic wait_quiet();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// quiet plus time for items that cause no access to leave the pipeline
	task automatic drain();
		wait_quiet();
		repeat (SettleCycles) @(posedge clk);
	endtask

	initial begin
		logic [15:0] seg_list [6];
		item_t       it;
		int          phase_start;
		int          pick;
		logic [4:0]  lvl;
		bit          paused;

		// segment settings, extremes first; stays at the reset value of zero
		// for the directed part
		seg_list[0] = 16'hffff;
		seg_list[1] = 16'h0000;
		seg_list[2] = 16'($urandom);
		seg_list[3] = 16'h8000;
		seg_list[4] = 16'($urandom);
		seg_list[5] = 16'h0001;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under the reset segment
		put(ACT_LOAD, 16'h0000, 16'h0000, 8'd0);    // both pointers at zero
		put(ACT_ENTER, 16'h0000, 16'h0000, 8'd0);   // level zero, push wraps below zero
		put(ACT_LOAD, 16'hffff, 16'hffff, 8'd0);    // both pointers at the top
		put(ACT_ENTER, 16'hffff, 16'h0000, 8'd1);   // level one, largest frame
		put(ACT_LEAVE, 16'h0000, 16'h0000, 8'd0);
		put(ACT_RDATA, 16'hffff, 16'h0000, 8'd0);   // leave completion
		put(ACT_RDATA, 16'h0000, 16'h0000, 8'd0);   // stray data while idle
		put(ACT_ENTER, 16'h0010, 16'h0000, 8'd2);   // one copy read
		put(ACT_LEAVE, 16'h0000, 16'h0000, 8'd0);   // wrong phase, ignored
		put(ACT_LOAD, 16'h1234, 16'h5678, 8'd0);    // wrong phase, ignored
		put(ACT_ENTER, 16'h0004, 16'h0000, 8'd3);   // wrong phase, ignored
		put(ACT_RDATA, 16'h0000, 16'h0000, 8'd0);
		put(ACT_ENTER, 16'h0008, 16'h0000, 8'd32);  // level wraps to zero
		put(ACT_ENTER, 16'h0002, 16'h0000, 8'd33);  // level wraps to one
		put(ACT_ENTER, 16'hffff, 16'h0000, 8'd3);   // two copy reads
		put(ACT_RDATA, 16'hffff, 16'h0000, 8'd0);
		put(ACT_RDATA, 16'h5a5a, 16'h0000, 8'd0);
		put(ACT_LEAVE, 16'h0000, 16'h0000, 8'd0);
		put(ACT_ENTER, 16'h0000, 16'h0000, 8'd0);   // enter during leave, ignored
		put(ACT_RDATA, 16'h0002, 16'h0000, 8'd0);
		put(ACT_LOAD, 16'h0001, 16'h8000, 8'd0);
		put(ACT_LEAVE, 16'h0000, 16'h0000, 8'd0);
		put(ACT_RDATA, 16'h0000, 16'h0000, 8'd0);

		// random part: three idle mixes, two segment settings each
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin tx_idle_pct = 24; rx_idle_pct = 51; end
				1: begin tx_idle_pct = 51; rx_idle_pct = 24; end
				default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
			endcase
			for (int half = 0; half < 2; half++) begin
				// segment writes only with the block idle and drained
				drain();
				cfg_valid <= 1'b1;
				cfg_data  <= seg_list[mode * 2 + half];
				do @(posedge clk); while (!cfg_ready);
				cfg_valid <= 1'b0;
				n_cfg++;

				phase_start = n_counted;
				paused      = 1'b0;
				// deepest nesting once: thirty copies
				if (mode == 0 && half == 0)
					put(ACT_ENTER, 16'h0006, 16'h0000, 8'hff);

				while (n_counted - phase_start < PhaseItems) begin
					// sender holds off once per phase until all results are in
					if (!paused && n_counted - phase_start >= 40) begin
						wait_quiet();
						paused = 1'b1;
					end
					it.action      = ACT_LOAD;
					it.frame_bytes = ($urandom_range(0, 3) == 0) ? 16'($urandom)
						: 16'($urandom_range(0, 64));
					pick = $urandom_range(0, 99);
					lvl  = (pick < 70) ? 5'($urandom_range(0, 4))
						: (pick < 90) ? 5'($urandom_range(5, 12))
						: 5'($urandom_range(13, 31));
					it.nest_level = {3'($urandom_range(0, 7)), lvl};
					it.read_data  = 16'($urandom);
					pick = $urandom_range(0, 99);
					it.load_sp = (pick < 15) ? 16'($urandom_range(0, 7))
						: (pick < 30) ? 16'($urandom_range(16'hfff8, 16'hffff))
						: 16'($urandom);
					it.load_bp = ($urandom_range(0, 3) == 0) ? it.load_sp + 16'h0010
						: 16'($urandom);
					pick = $urandom_range(0, 99);
					if (seq_phase == PH_IDLE) begin
						// mostly well-formed starts, a few stray data returns
						if (pick < 38)
							it.action = ACT_ENTER;
						else if (pick < 63)
							it.action = ACT_LEAVE;
						else if (pick < 90)
							it.action = ACT_LOAD;
						else
							it.action = ACT_RDATA;
					end else begin
						// mostly the data the block waits for, some out-of-phase noise
						if (pick < 88)
							it.action = ACT_RDATA;
						else if (pick < 92)
							it.action = ACT_ENTER;
						else if (pick < 96)
							it.action = ACT_LEAVE;
						else
							it.action = ACT_LOAD;
					end
					issue(it);
				end
				// close any open sequence so the next segment write finds it idle
				while (seq_phase != PH_IDLE)
					put(ACT_RDATA, 16'($urandom), 16'h0000, 8'd0);
			end
		end

		drain();
		wrap_up <= 1'b1;
		repeat (2) @(posedge clk);

		$display("covered %0d items: %0d enter, %0d leave, %0d data returns, %0d loads",
			n_counted, n_enter, n_leave, n_rdata, n_load);
		$display("plus %0d out-of-phase items, over %0d segment settings and three idle mixes",
			n_ignored, n_cfg + 1);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
